>>> rtl/core/fdcr_pkg.sv
// Shared widths and codes for the filled disk rasteriser.
package fdcr_pkg;

  localparam int COORD_BITS  = 12;
  localparam int RADIUS_BITS = 11;
  // Decision variable width and pixel coordinate width
  localparam int DEC_BITS    = RADIUS_BITS + 3;
  localparam int PIX_BITS    = COORD_BITS + 2;
  // Working widths for the decision update and the pixel sums
  localparam int DW          = DEC_BITS + 2;
  localparam int OW          = RADIUS_BITS + 2;
  localparam int SW          = (PIX_BITS > OW + 1) ? PIX_BITS : OW + 1;

  // Step command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  localparam logic [2:0] OCT_LAST = 3'd7;

endpackage

>>> rtl/core/filled_disk_circle_rasterizer.sv
// Filled disk rasteriser: concentric midpoint-style circles, one pixel per step beat.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------
//  in      | in_valid / in_ready  | cmd, center_x, center_y, radius
//  out     | out_valid/ out_ready | pixel_valid, pixel_x, pixel_y, done_res
//
// For each input beat, the octant select, the pixel adds and the decision update
// sit between the state registers and the result register.
// One result beat per input beat; a new beat is taken every cycle while the
// result register is empty or being drained.
// Reset (rst, synchronous) leaves the block idle with an empty result register.
// A stalled output holds the result and blocks input until it is taken.
module filled_disk_circle_rasterizer (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic                                     cmd,
  input  logic [fdcr_pkg::COORD_BITS-1:0]          center_x,
  input  logic [fdcr_pkg::COORD_BITS-1:0]          center_y,
  input  logic [fdcr_pkg::RADIUS_BITS-1:0]         radius,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic                                     pixel_valid,
  output logic signed [fdcr_pkg::PIX_BITS-1:0]     pixel_x,
  output logic signed [fdcr_pkg::PIX_BITS-1:0]     pixel_y,
  output logic                                     done_res
);

  localparam int RB = fdcr_pkg::RADIUS_BITS;
  localparam int CB = fdcr_pkg::COORD_BITS;
  localparam int DB = fdcr_pkg::DEC_BITS;
  localparam int PB = fdcr_pkg::PIX_BITS;
  localparam int DW = fdcr_pkg::DW;
  localparam int OW = fdcr_pkg::OW;
  localparam int SW = fdcr_pkg::SW;

  // Disk state
  logic [CB-1:0]        disk_center_x;
  logic [CB-1:0]        disk_center_y;
  logic [RB-1:0]        current_radius;
  logic [RB-1:0]        offset_x;
  logic [RB-1:0]        offset_y;
  logic signed [DB-1:0] decision;
  logic [2:0]           octant_index;
  logic                 busy;

  logic accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Octant point selection
  logic signed [OW-1:0] xs, ys, dx, dy;
  assign xs = signed'({2'b00, offset_x});
  assign ys = signed'({2'b00, offset_y});

  always_comb begin
    case (octant_index)
      3'd0:    begin dx = xs;  dy = ys;  end
      3'd1:    begin dx = ys;  dy = xs;  end
      3'd2:    begin dx = -xs; dy = ys;  end
      3'd3:    begin dx = -ys; dy = xs;  end
      3'd4:    begin dx = xs;  dy = -ys; end
      3'd5:    begin dx = ys;  dy = -xs; end
      3'd6:    begin dx = -xs; dy = -ys; end
      default: begin dx = -ys; dy = -xs; end
    endcase
  end

  // Pixel sums, centre zero-extended and offset sign-extended
  logic signed [SW-1:0] sum_x, sum_y;
  assign sum_x = signed'(SW'(disk_center_x)) + SW'(dx);
  assign sum_y = signed'(SW'(disk_center_y)) + SW'(dy);

  // Decision update after the last octant point
  logic signed [DW-1:0] d_w, x2, y2, ry2, d_upd;
  logic signed [OW-1:0] x_upd, y_upd;
  logic                 circle_end;

  assign d_w = signed'({{(DW-DB){decision[DB-1]}}, decision});
  assign x2  = signed'({{(DW-RB-1){1'b0}}, offset_x, 1'b0});
  assign y2  = signed'({{(DW-RB-1){1'b0}}, offset_y, 1'b0});
  assign ry2 = (signed'(DW'(current_radius)) - signed'(DW'(offset_y))) <<< 1;

  always_comb begin
    if (d_w >= x2) begin
      d_upd = d_w - x2 - DW'(1);
      x_upd = xs + OW'(1);
      y_upd = ys;
    end else if (d_w < ry2) begin
      d_upd = d_w + y2 - DW'(1);
      x_upd = xs;
      y_upd = ys - OW'(1);
    end else begin
      d_upd = d_w + y2 - x2 - DW'(2);
      x_upd = xs + OW'(1);
      y_upd = ys - OW'(1);
    end
  end

  assign circle_end = y_upd < x_upd;

  // State update on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      disk_center_x  <= '0;
      disk_center_y  <= '0;
      current_radius <= '0;
      offset_x       <= '0;
      offset_y       <= '0;
      decision       <= '0;
      octant_index   <= '0;
      busy           <= 1'b0;
    end else if (accept) begin
      if (cmd == fdcr_pkg::CMD_START) begin
        disk_center_x  <= center_x;
        disk_center_y  <= center_y;
        current_radius <= radius;
        offset_x       <= '0;
        offset_y       <= radius;
        decision       <= signed'(DB'(radius)) - DB'(1);
        octant_index   <= '0;
        busy           <= (radius != '0);
      end else if (busy) begin
        if (octant_index == fdcr_pkg::OCT_LAST) begin
          octant_index <= '0;
          if (circle_end) begin
            current_radius <= current_radius - RB'(1);
            offset_x       <= '0;
            if (current_radius == RB'(1)) begin
              busy     <= 1'b0;
              offset_y <= '0;
              decision <= '0;
            end else begin
              offset_y <= current_radius - RB'(1);
              decision <= signed'(DB'(current_radius)) - DB'(2);
            end
          end else begin
            offset_x <= x_upd[RB-1:0];
            offset_y <= y_upd[RB-1:0];
            decision <= d_upd[DB-1:0];
          end
        end else begin
          octant_index <= octant_index + 3'd1;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (cmd == fdcr_pkg::CMD_START) begin
        pixel_valid <= 1'b1;
        pixel_x     <= signed'(PB'(center_x));
        pixel_y     <= signed'(PB'(center_y));
        done_res    <= (radius == '0);
      end else if (busy) begin
        pixel_valid <= 1'b1;
        pixel_x     <= sum_x[PB-1:0];
        pixel_y     <= sum_y[PB-1:0];
        done_res    <= (octant_index == fdcr_pkg::OCT_LAST) && circle_end
                       && (current_radius == RB'(1));
      end else begin
        pixel_valid <= 1'b0;
        pixel_x     <= '0;
        pixel_y     <= '0;
        done_res    <= 1'b0;
      end
    end
  end

endmodule

>>> tb/sv/filled_disk_circle_rasterizer_test.sv
// Self-checking testbench for the filled disk rasteriser: pixel predictor, scoreboard, stimulus.
`timescale 1ns / 1ps

// Tracks the disk being drawn and holds the pixels still owed by the block
class disk_pixel_scoreboard;

  typedef struct packed {
    logic                                 pix_on;
    logic signed [fdcr_pkg::PIX_BITS-1:0] col;
    logic signed [fdcr_pkg::PIX_BITS-1:0] row;
    logic                                 last;
  } pixel_t;

  pixel_t pending_pixels[$];
  int     mismatches;

  // Predicted disk state
  logic [fdcr_pkg::COORD_BITS-1:0]      ctr_x, ctr_y;
  logic [fdcr_pkg::RADIUS_BITS-1:0]     rad, off_x, off_y;
  logic signed [fdcr_pkg::DEC_BITS-1:0] dec;
  logic [2:0]                           octant;
  bit                                   drawing;

  function new();
    ctr_x = '0;
    ctr_y = '0;
    rad = '0;
    off_x = '0;
    off_y = '0;
    dec = '0;
    octant = '0;
    drawing = 1'b0;
    mismatches = 0;
  endfunction

  // Fresh circle at the current radius: top point, decision r-1
  function void restart_circle();
    int d;
    d = int'(rad) - 1;
    off_x = '0;
    off_y = rad;
    dec = d[fdcr_pkg::DEC_BITS-1:0];
    octant = '0;
  endfunction

  // Work out the pixel for one accepted input beat and queue it
  function void note_beat(logic c, logic [fdcr_pkg::COORD_BITS-1:0] cx,
                          logic [fdcr_pkg::COORD_BITS-1:0] cy,
                          logic [fdcr_pkg::RADIUS_BITS-1:0] r);
    pixel_t p;
    int x, y, dx, dy, d, sum;
    p = '0;
    if (c == fdcr_pkg::CMD_START) begin
      ctr_x = cx;
      ctr_y = cy;
      rad = r;
      restart_circle();
      drawing = (r != 0);
      p.pix_on = 1'b1;
      sum = int'(cx);
      p.col = sum[fdcr_pkg::PIX_BITS-1:0];
      sum = int'(cy);
      p.row = sum[fdcr_pkg::PIX_BITS-1:0];
      p.last = !drawing;
    end else if (drawing) begin
      x = int'(off_x);
      y = int'(off_y);
      // Eight symmetric points, fixed order
      case (octant)
        3'd0: begin dx = x;  dy = y;  end
        3'd1: begin dx = y;  dy = x;  end
        3'd2: begin dx = -x; dy = y;  end
        3'd3: begin dx = -y; dy = x;  end
        3'd4: begin dx = x;  dy = -y; end
        3'd5: begin dx = y;  dy = -x; end
        3'd6: begin dx = -x; dy = -y; end
        default: begin dx = -y; dy = -x; end
      endcase
      p.pix_on = 1'b1;
      sum = int'(ctr_x) + dx;
      p.col = sum[fdcr_pkg::PIX_BITS-1:0];
      sum = int'(ctr_y) + dy;
      p.row = sum[fdcr_pkg::PIX_BITS-1:0];
      if (octant == fdcr_pkg::OCT_LAST) begin
        // Andres decision step
        d = int'(dec);
        if (d >= 2 * x) begin
          d = d - (2 * x + 1);
          x = x + 1;
        end else if (d < 2 * (int'(rad) - y)) begin
          d = d + 2 * y - 1;
          y = y - 1;
        end else begin
          d = d + 2 * (y - x - 1);
          y = y - 1;
          x = x + 1;
        end
        if (y < x) begin
          // Circle complete: shrink radius or finish the disk
          rad = rad - 1'b1;
          if (rad == 0) begin
            drawing = 1'b0;
            p.last = 1'b1;
            off_x = '0;
            off_y = '0;
            dec = '0;
            octant = '0;
          end else begin
            restart_circle();
          end
        end else begin
          off_x = x[fdcr_pkg::RADIUS_BITS-1:0];
          off_y = y[fdcr_pkg::RADIUS_BITS-1:0];
          dec = d[fdcr_pkg::DEC_BITS-1:0];
          octant = '0;
        end
      end else begin
        octant = octant + 1'b1;
      end
    end
    pending_pixels.push_back(p);
  endfunction

  task report_mismatch(string msg);
    $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  // Compare one result beat against the oldest queued pixel
  task check_pixel(logic pv, logic signed [fdcr_pkg::PIX_BITS-1:0] px,
                   logic signed [fdcr_pkg::PIX_BITS-1:0] py, logic dn);
    pixel_t e;
    if (pending_pixels.size() == 0) begin
      report_mismatch("result beat with no pixel outstanding");
      return;
    end
    e = pending_pixels.pop_front();
    if (pv !== e.pix_on)
      report_mismatch($sformatf("pixel_valid %b, want %b", pv, e.pix_on));
    if (px !== e.col)
      report_mismatch($sformatf("pixel_x %0d, want %0d", px, e.col));
    if (py !== e.row)
      report_mismatch($sformatf("pixel_y %0d, want %0d", py, e.row));
    if (dn !== e.last)
      report_mismatch($sformatf("done_res %b, want %b", dn, e.last));
  endtask

endclass

module filled_disk_circle_rasterizer_test;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 in_valid = 1'b0;
  logic                                 in_ready;
  logic                                 cmd = fdcr_pkg::CMD_STEP;
  logic [fdcr_pkg::COORD_BITS-1:0]      center_x = '0;
  logic [fdcr_pkg::COORD_BITS-1:0]      center_y = '0;
  logic [fdcr_pkg::RADIUS_BITS-1:0]     radius = '0;
  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  logic                                 pixel_valid;
  logic signed [fdcr_pkg::PIX_BITS-1:0] pixel_x;
  logic signed [fdcr_pkg::PIX_BITS-1:0] pixel_y;
  logic                                 done_res;

  disk_pixel_scoreboard sb;
  int beats_sent = 0;
  int gap_pct = 0;
  int stall_pct = 0;

  filled_disk_circle_rasterizer i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .center_x(center_x),
    .center_y(center_y),
    .radius(radius),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pixel_valid(pixel_valid),
    .pixel_x(pixel_x),
    .pixel_y(pixel_y),
    .done_res(done_res)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Result side: check accepted beats, then pick next cycle's ready
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_pixel(pixel_valid, pixel_x, pixel_y, done_res);
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // One input beat, with an optional idle gap ahead of it
  task automatic send_beat(input logic c, input logic [fdcr_pkg::COORD_BITS-1:0] cx,
                           input logic [fdcr_pkg::COORD_BITS-1:0] cy,
                           input logic [fdcr_pkg::RADIUS_BITS-1:0] r);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid <= 1'b1;
    cmd <= c;
    center_x <= cx;
    center_y <= cy;
    radius <= r;
    do @(posedge clk); while (!in_ready);
    sb.note_beat(c, cx, cy, r);
    beats_sent++;
  endtask

  // Start a disk, then step until it finishes or the step budget runs out
  task automatic draw_disk(input logic [fdcr_pkg::COORD_BITS-1:0] cx,
                           input logic [fdcr_pkg::COORD_BITS-1:0] cy,
                           input logic [fdcr_pkg::RADIUS_BITS-1:0] r, input int max_steps);
    int n;
    n = 0;
    send_beat(fdcr_pkg::CMD_START, cx, cy, r);
    while (sb.drawing && n < max_steps) begin
      send_beat(fdcr_pkg::CMD_STEP, 12'($urandom), 12'($urandom), 11'($urandom));
      n++;
    end
  endtask

  initial begin
    logic [fdcr_pkg::COORD_BITS-1:0] cx, cy;
    int pick;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: idle step, zero radius at both corners, abandoned big disks, a full tiny disk
    send_beat(fdcr_pkg::CMD_STEP, 12'hfff, 12'hfff, 11'h7ff);
    send_beat(fdcr_pkg::CMD_START, 12'h000, 12'h000, 11'h000);
    send_beat(fdcr_pkg::CMD_START, 12'hfff, 12'hfff, 11'h000);
    draw_disk(12'hfff, 12'h000, 11'h7ff, 2);
    draw_disk(12'h000, 12'hfff, 11'h7ff, 1);
    draw_disk(12'h000, 12'h000, 11'd1, 100);
    send_beat(fdcr_pkg::CMD_STEP, 12'h000, 12'h000, 11'h000);

    // Random disks, cycling through the idling phases
    while (beats_sent < 1150) begin
      case (beats_sent * 5 / 1150)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 81; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 81; end
        3: begin gap_pct = 16; stall_pct = 16; end
        default: begin gap_pct = 0; stall_pct = 0; end
      endcase
      cx = 12'($urandom);
      cy = 12'($urandom);
      // Pull some centres onto the edges so pixels wrap negative or past the surface
      if ($urandom_range(3) == 0)
        cx = $urandom_range(1) ? 12'($urandom_range(8)) : 12'(4095 - $urandom_range(8));
      if ($urandom_range(3) == 0)
        cy = $urandom_range(1) ? 12'($urandom_range(8)) : 12'(4095 - $urandom_range(8));
      pick = $urandom_range(99);
      if (pick < 70)
        draw_disk(cx, cy, 11'($urandom_range(5)),
                  ($urandom_range(9) == 0) ? $urandom_range(30) : 100000);
      else if (pick < 82)
        draw_disk(cx, cy, 11'($urandom_range(9, 6)), 100000);
      else
        draw_disk(cx, cy, 11'($urandom), $urandom_range(40));
      // Occasional steps after the disk has ended
      if (!sb.drawing && $urandom_range(9) < 3)
        repeat ($urandom_range(3, 1))
          send_beat(fdcr_pkg::CMD_STEP, 12'($urandom), 12'($urandom), 11'($urandom));
    end
    in_valid <= 1'b0;

    // Drain, then wait out any stray beats
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0)
      $display("filled_disk_circle_rasterizer_test: clean");
    else
      $display("filled_disk_circle_rasterizer_test: errors");
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("filled_disk_circle_rasterizer_test: errors");
    $finish;
  end

endmodule
